>>> rtl/wf_pkg.sv
// wf_pkg: shared types, constants and lookup tables for the wildfire cell update.
// No dependencies; used by wf_lane and wildfire_cell_next_state.
package wf_pkg;

  typedef enum logic [1:0] {
    CELL_BURNING = 2'd0,
    CELL_FUEL    = 2'd1,
    CELL_NOFUEL  = 2'd2,
    CELL_BURNT   = 2'd3
  } cell_state_t;

  localparam logic [15:0] WIND_RESET = 16'd7300;
  localparam logic [13:0] P0_Q14     = 14'd9503;
  localparam logic [14:0] P_ONE      = 15'd16384;
  localparam int unsigned NUM_LANES  = 8;

  // wind factor, Q1.14, at angle i*2048
  function automatic logic [14:0] pw_tab(input logic [4:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd25695;
      5'd1:    v = 15'd25057;
      5'd2:    v = 15'd23257;
      5'd3:    v = 15'd20605;
      5'd4:    v = 15'd17507;
      5'd5:    v = 15'd14355;
      5'd6:    v = 15'd11446;
      5'd7:    v = 15'd8952;
      5'd8:    v = 15'd6933;
      5'd9:    v = 15'd5370;
      5'd10:   v = 15'd4200;
      5'd11:   v = 15'd3348;
      5'd12:   v = 15'd2746;
      5'd13:   v = 15'd2333;
      5'd14:   v = 15'd2067;
      5'd15:   v = 15'd1918;
      default: v = 15'd1871;
    endcase
    return v;
  endfunction

  // slope factor, Q1.14, at slope i*4096
  function automatic logic [14:0] ps_tab(input logic [3:0] i);
    logic [14:0] v;
    case (i)
      4'd0:    v = 15'd16384;
      4'd1:    v = 15'd16707;
      4'd2:    v = 15'd17036;
      4'd3:    v = 15'd17371;
      4'd4:    v = 15'd17713;
      4'd5:    v = 15'd18062;
      4'd6:    v = 15'd18418;
      4'd7:    v = 15'd18780;
      default: v = 15'd19150;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/wf_chan_if.sv
// wf_in_if / wf_out_if: valid/ready channels for cell requests and results.
// No dependencies.
interface wf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cell_state;
  logic signed [14:0] veg_type;
  logic signed [14:0] veg_density;
  logic [14:0] slope_angle;
  logic [7:0]  burning_neighbours;
  logic [63:0] random_low;
  logic [63:0] random_high;

  modport source (output valid, cell_state, veg_type, veg_density, slope_angle,
                  burning_neighbours, random_low, random_high, input ready);
  modport sink   (input valid, cell_state, veg_type, veg_density, slope_angle,
                  burning_neighbours, random_low, random_high, output ready);
endinterface

interface wf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] next_state;

  modport source (output valid, next_state, input ready);
  modport sink   (input valid, next_state, output ready);
endinterface

>>> rtl/wf_lane.sv
// wf_lane: ignition test for one neighbor direction (wind factor, probability
// chain, random compare). Depends on wf_pkg.
module wf_lane #(
  parameter int unsigned K           = 0,
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] wind,
  input  logic [15:0] base_s1,
  input  logic [14:0] ps_s2,
  input  logic [15:0] slot,
  output logic        hit_r
);
  import wf_pkg::*;

  localparam int unsigned RBU = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;

  logic [15:0] d_raw, d_fold;
  logic [4:0]  idx;
  logic [10:0] frac;
  logic [14:0] t0, t1, pw_nxt, pw_r;
  logic [25:0] dprod;
  logic [15:0] slot1_r, slot2_r, slot3_r;
  logic [31:0] p1_full;
  logic [16:0] p1_r, p2_r;
  logic [31:0] p2_full;
  logic [30:0] p3_full;
  logic [16:0] p3;
  logic [14:0] psat;
  logic [RBU-1:0] rv;
  logic hit_nxt;

  always_comb begin
    d_raw  = {3'(K), 13'd0} - wind;
    d_fold = (d_raw > 16'd32768) ? 16'(17'd65536 - {1'b0, d_raw}) : d_raw;
    idx    = d_fold[15:11];
    frac   = d_fold[10:0];
    t0     = pw_tab(idx);
    t1     = pw_tab(5'(idx + 5'd1));
    dprod  = 26'(t0 - t1) * 26'(frac);
    pw_nxt = (idx >= 5'd16) ? pw_tab(5'd16) : 15'(t0 - 15'(dprod >> 11));
  end

  always_ff @(posedge clk) begin
    pw_r <= pw_nxt;
  end

  assign p1_full = 32'(base_s1) * 32'(pw_r);
  assign p2_full = 32'(p1_r) * 32'(ps_s2);
  assign p3_full = 31'(p2_r) * 31'(P0_Q14);
  assign p3      = 17'(p3_full >> 14);
  assign psat    = (p3 > 17'(P_ONE)) ? P_ONE : p3[14:0];
  assign rv      = slot3_r[15 -: RBU];
  assign hit_nxt = ((RBU+15)'({rv, 14'd0})) < ((RBU+15)'({psat, {RBU{1'b0}}}));

  always_ff @(posedge clk) begin
    if (en) begin
      slot1_r <= slot;
      slot2_r <= slot1_r;
      slot3_r <= slot2_r;
      p1_r    <= 17'(p1_full >> 14);
      p2_r    <= 17'(p2_full >> 14);
      hit_r   <= hit_nxt;
    end
  end

endmodule

>>> rtl/wildfire_cell_next_state.sv
// wildfire_cell_next_state: top level, shared factors, eight wf_lane copies and merge.
// Depends on wf_pkg, wf_in_if/wf_out_if, wf_lane.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | cell fields, neighbor mask, random slots
//  out_ch  | out | valid/ready        | next_state
//  cfg     | in  | cfg_we             | cfg_wdata = wind_direction
//
// One request per cycle while no result waits on a low out_ch.ready; registered
// through the factor stage, three multiply stages inside each lane, and the merge into the output register.
// Synchronous active-low reset clears valid flags and loads wind 7300.
// The whole pipeline holds while a result waits and out_ch.ready is low.
module wildfire_cell_next_state #(
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  wf_in_if.sink       in_ch,
  wf_out_if.source    out_ch
);
  import wf_pkg::*;

  logic        en;
  logic [15:0] wind_r;
  logic [3:0]  v_r;
  logic [1:0]  st_r [4];
  logic [7:0]  mask_r [4];
  logic [15:0] base_r;
  logic [14:0] ps_r, ps2_r;
  logic [14:0] opa, opb;
  logic [29:0] bprod;
  logic [14:0] s0, s1t;
  logic [26:0] sprod;
  logic [14:0] ps_nxt;
  logic [NUM_LANES-1:0] hit;
  logic [127:0] rnd;
  logic        out_valid_r;
  logic [1:0]  next_r, next_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_state = next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r <= WIND_RESET;
    end else if (cfg_we) begin
      wind_r <= cfg_wdata;
    end
  end

  // 1 + x for Q1.14 fields is a flip of bit 14
  assign opa   = in_ch.veg_type ^ 15'h4000;
  assign opb   = in_ch.veg_density ^ 15'h4000;
  assign bprod = 30'(opa) * 30'(opb);
  assign s0    = ps_tab({1'b0, in_ch.slope_angle[14:12]});
  assign s1t   = ps_tab(4'({1'b0, in_ch.slope_angle[14:12]} + 4'd1));
  assign sprod = 27'(s1t - s0) * 27'(in_ch.slope_angle[11:0]);
  assign ps_nxt = 15'(s0 + 15'(sprod >> 12));
  assign rnd   = {in_ch.random_high, in_ch.random_low};

  always_ff @(posedge clk) begin
    if (en) begin
      base_r    <= 16'(bprod >> 14);
      ps_r      <= ps_nxt;
      ps2_r     <= ps_r;
      st_r[0]   <= in_ch.cell_state;
      mask_r[0] <= in_ch.burning_neighbours;
      for (int i = 1; i < 4; i++) begin
        st_r[i]   <= st_r[i-1];
        mask_r[i] <= mask_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[2:0], in_ch.valid};
      out_valid_r <= v_r[3];
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    wf_lane #(
      .K           (k),
      .RANDOM_BITS (RANDOM_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .wind    (wind_r),
      .base_s1 (base_r),
      .ps_s2   (ps2_r),
      .slot    (rnd[16*k +: 16]),
      .hit_r   (hit[k])
    );
  end

  always_comb begin
    next_nxt = st_r[3];
    case (cell_state_t'(st_r[3]))
      CELL_BURNING: next_nxt = CELL_BURNT;
      CELL_FUEL:    next_nxt = (|(hit & mask_r[3])) ? CELL_BURNING : CELL_FUEL;
      default:      next_nxt = st_r[3];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_r <= next_nxt;
    end
  end

endmodule
